/* design/address_table_with_lru_eviction_assert.svh */
// Assertion macros for the address table checker.
// Relies on clk and rst_n being visible where the macros are used.
`ifndef ADDRESS_TABLE_WITH_LRU_EVICTION_ASSERT_SVH
`define ADDRESS_TABLE_WITH_LRU_EVICTION_ASSERT_SVH

// same-cycle implication
`define ATLRU_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATLRU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/atlru_pkg.sv */
// Shared constants for the address table with LRU replacement.
// No dependencies.
`timescale 1ns / 1ps

package atlru_pkg;

    localparam int SLOT_W = 8;          // slot handle width
    localparam int PTR_W  = 9;          // pointer width, top bit marks empty
    localparam int KEY_W  = 32;
    localparam int NSLOT  = 256;
    localparam int NBKT   = 256;
    localparam int NGRP   = NSLOT / 8;  // free search groups of eight slots
    localparam int GRP_W  = 5;

    localparam logic [PTR_W-1:0] NIL = 9'd256;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_FIND   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_MISS = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_NEW  = 2'd2;
    localparam logic [1:0] ST_OVER = 2'd3;

    localparam logic REG_EVICT_EN = 1'b0;
    localparam logic REG_MAX      = 1'b1;

endpackage

/* design/atlru_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module atlru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/address_table_with_lru_eviction.sv */
// Address table with LRU replacement: sequencer, pointer memories, output stage.
// Depends on atlru_pkg and atlru_ram.
//
// Usage
// - Input channel (in_valid/in_ready) carries one item: mode and key.
//   mode insert appends key to its bucket chain (bucket = key bits 9:2),
//   find returns the earliest matching entry, clear empties the table.
// - Output channel (out_valid/out_ready) returns exactly one result item
//   per input item, held in an output register until taken.
// - APB port: register 0 at 0x0 evict_enable, register 1 at 0x4 max_entries.
//   Write them only while the block is idle.
// - Steps: find reads the bucket head and walks the chain, then moves a
//   hit to the front of the recency list. Insert unlinks the least recent
//   entry when over max_entries, reads the bucket head, picks a free slot,
//   walks to the bucket tail to append it and moves it to the front.
//   With evict_enable 0, find returns the bucket's slot unchecked and insert
//   overwrites it. The RAMs have a registered read; clear needs no memory walk.
// - One item is in work at a time; in_ready is high only while idle, but a
//   finished result waiting in the output register does not block the
//   next item from being taken.
// - Reset: valid bits for slots and bucket heads live in flops and clear at
//   once, so no clearing pass is needed; registers go to evict_enable=1,
//   max_entries=254.
// - When the receiver stalls, the next result waits in the done state
//   until the output register frees.
`timescale 1ns / 1ps

module address_table_with_lru_eviction (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // items in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [atlru_pkg::KEY_W-1:0]    key,
    // items out
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [atlru_pkg::SLOT_W-1:0]   handle,
    output logic [atlru_pkg::KEY_W-1:0]    stored_key,
    output logic                           evicted,
    output logic [atlru_pkg::SLOT_W-1:0]   evicted_handle,
    output logic [atlru_pkg::KEY_W-1:0]    evicted_key,
    output logic [atlru_pkg::PTR_W-1:0]    entry_count
);

    import atlru_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_F_HEAD = 5'd1;
    localparam logic [4:0] S_F_HD2  = 5'd2;
    localparam logic [4:0] S_F_RD   = 5'd3;
    localparam logic [4:0] S_F_CMP  = 5'd4;
    localparam logic [4:0] S_UL_RD  = 5'd5;
    localparam logic [4:0] S_UL_WR  = 5'd6;
    localparam logic [4:0] S_FR1    = 5'd7;
    localparam logic [4:0] S_FR2    = 5'd8;
    localparam logic [4:0] S_EV0    = 5'd9;
    localparam logic [4:0] S_EV_RD  = 5'd10;
    localparam logic [4:0] S_EV_HD  = 5'd11;
    localparam logic [4:0] S_EV_HD2 = 5'd12;
    localparam logic [4:0] S_EV_WK  = 5'd13;
    localparam logic [4:0] S_EV_WK2 = 5'd14;
    localparam logic [4:0] S_EV_FIN = 5'd15;
    localparam logic [4:0] S_I_CHK  = 5'd16;
    localparam logic [4:0] S_I_HEAD = 5'd17;
    localparam logic [4:0] S_I_HD2  = 5'd18;
    localparam logic [4:0] S_FS1    = 5'd19;
    localparam logic [4:0] S_FS2    = 5'd20;
    localparam logic [4:0] S_I_ALOC = 5'd21;
    localparam logic [4:0] S_I_H3   = 5'd22;
    localparam logic [4:0] S_I_WK   = 5'd23;
    localparam logic [4:0] S_I_WK2  = 5'd24;
    localparam logic [4:0] S_DONE   = 5'd25;

    // control state
    logic [4:0]        st_reg, st_next;
    logic [NSLOT-1:0]  valid_reg, valid_next;     // slot occupied
    logic [NBKT-1:0]   bv_reg, bv_next;           // bucket head written since clear
    logic [PTR_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  mr_reg, mr_next;           // most recent
    logic [PTR_W-1:0]  lr_reg, lr_next;           // least recent
    logic              evict_en_reg, evict_en_next;
    logic [7:0]        max_reg, max_next;
    logic              out_valid_reg, out_valid_next;

    // working registers for the item in hand
    logic [1:0]        mode_reg, mode_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  s_reg, s_next;
    logic [PTR_W-1:0]  cn_reg, cn_next;           // chain successor of victim
    logic [7:0]        eb_reg, eb_next;           // victim's bucket
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic              grp_ok_reg, grp_ok_next;
    logic              ev_ret_reg, ev_ret_next;   // eviction returns to free search
    logic              ul_ret_reg, ul_ret_next;   // unlink belongs to an eviction
    logic              tried_reg, tried_next;
    logic [1:0]        status_reg, status_next;
    logic [SLOT_W-1:0] hdl_reg, hdl_next;
    logic [KEY_W-1:0]  skey_reg, skey_next;
    logic              ev_reg, ev_next;
    logic [SLOT_W-1:0] evh_reg, evh_next;
    logic [KEY_W-1:0]  evk_reg, evk_next;

    // output register
    logic [1:0]        o_status_reg, o_status_next;
    logic [SLOT_W-1:0] o_hdl_reg, o_hdl_next;
    logic [KEY_W-1:0]  o_skey_reg, o_skey_next;
    logic              o_ev_reg, o_ev_next;
    logic [SLOT_W-1:0] o_evh_reg, o_evh_next;
    logic [KEY_W-1:0]  o_evk_reg, o_evk_next;
    logic [PTR_W-1:0]  o_cnt_reg, o_cnt_next;

    // memory ports
    logic              mk_we, mc_we, mp_we, mn_we, mh_we;
    logic [7:0]        mk_wa, mc_wa, mp_wa, mn_wa, mh_wa;
    logic [7:0]        mk_ra, mc_ra, mh_ra;
    logic [KEY_W-1:0]  mk_wd, mk_rd;
    logic [PTR_W-1:0]  mc_wd, mp_wd, mn_wd, mh_wd;
    logic [PTR_W-1:0]  mc_rd, mp_rd, mn_rd, mh_rd;

    logic [7:0]        bkt;
    logic [PTR_W-1:0]  head_cur, head_ev;
    logic              grp_found;
    logic [GRP_W-1:0]  grp_idx;
    logic [7:0]        grp_bits;
    logic [2:0]        bit_idx;
    logic              cfg_wr;

    atlru_ram #(.WIDTH(KEY_W), .DEPTH(NSLOT)) u_key (
        .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd)
    );
    atlru_ram #(.WIDTH(PTR_W), .DEPTH(NSLOT)) u_chain (
        .clk(clk), .we(mc_we), .waddr(mc_wa), .wdata(mc_wd), .raddr(mc_ra), .rdata(mc_rd)
    );
    atlru_ram #(.WIDTH(PTR_W), .DEPTH(NSLOT)) u_prev (
        .clk(clk), .we(mp_we), .waddr(mp_wa), .wdata(mp_wd), .raddr(s_reg[7:0]),
        .rdata(mp_rd)
    );
    atlru_ram #(.WIDTH(PTR_W), .DEPTH(NSLOT)) u_next (
        .clk(clk), .we(mn_we), .waddr(mn_wa), .wdata(mn_wd), .raddr(s_reg[7:0]),
        .rdata(mn_rd)
    );
    atlru_ram #(.WIDTH(PTR_W), .DEPTH(NBKT)) u_head (
        .clk(clk), .we(mh_we), .waddr(mh_wa), .wdata(mh_wd), .raddr(mh_ra), .rdata(mh_rd)
    );

    assign bkt      = key_reg[9:2];
    // a head not written since clear reads as empty
    assign head_cur = bv_reg[bkt] ? mh_rd : NIL;
    assign head_ev  = bv_reg[eb_reg] ? mh_rd : NIL;

    assign mh_ra = (st_reg == S_EV_HD) ? mk_rd[9:2] : bkt;
    assign mk_ra = (st_reg == S_EV_RD) ? s_reg[7:0] : cur_reg[7:0];
    assign mc_ra = (st_reg == S_EV_RD) ? s_reg[7:0] : cur_reg[7:0];

    // free slot search, first level: lowest group of eight with a hole
    always_comb
    begin
        grp_found = 1'b0;
        grp_idx   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (!(&valid_reg[g*8 +: 8]))
            begin
                grp_found = 1'b1;
                grp_idx   = GRP_W'(g);
            end
        end
    end

    // second level: lowest hole inside the chosen group
    assign grp_bits = valid_reg[grp_reg*8 +: 8];
    always_comb
    begin
        bit_idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!grp_bits[i])
            begin
                bit_idx = 3'(i);
            end
        end
    end

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX) ? {24'd0, max_reg} : {31'd0, evict_en_reg};

    always_comb
    begin
        st_next        = st_reg;
        valid_next     = valid_reg;
        bv_next        = bv_reg;
        count_next     = count_reg;
        mr_next        = mr_reg;
        lr_next        = lr_reg;
        evict_en_next  = evict_en_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        cn_next        = cn_reg;
        eb_next        = eb_reg;
        grp_next       = grp_reg;
        grp_ok_next    = grp_ok_reg;
        ev_ret_next    = ev_ret_reg;
        ul_ret_next    = ul_ret_reg;
        tried_next     = tried_reg;
        status_next    = status_reg;
        hdl_next       = hdl_reg;
        skey_next      = skey_reg;
        ev_next        = ev_reg;
        evh_next       = evh_reg;
        evk_next       = evk_reg;
        o_status_next  = o_status_reg;
        o_hdl_next     = o_hdl_reg;
        o_skey_next    = o_skey_reg;
        o_ev_next      = o_ev_reg;
        o_evh_next     = o_evh_reg;
        o_evk_next     = o_evk_reg;
        o_cnt_next     = o_cnt_reg;

        mk_we = 1'b0; mk_wa = cur_reg[7:0]; mk_wd = key_reg;
        mc_we = 1'b0; mc_wa = cur_reg[7:0]; mc_wd = NIL;
        mp_we = 1'b0; mp_wa = s_reg[7:0];   mp_wd = NIL;
        mn_we = 1'b0; mn_wa = s_reg[7:0];   mn_wd = NIL;
        mh_we = 1'b0; mh_wa = bkt;          mh_wd = s_reg;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX)
            begin
                max_next = pwdata[7:0];
            end
            else
            begin
                evict_en_next = pwdata[0];
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode;
                    key_next    = key;
                    status_next = ST_MISS;
                    hdl_next    = '0;
                    skey_next   = '0;
                    ev_next     = 1'b0;
                    evh_next    = '0;
                    evk_next    = '0;
                    tried_next  = 1'b0;
                    unique case (mode)
                        MODE_CLEAR:
                        begin
                            valid_next = '0;
                            bv_next    = '0;
                            mr_next    = NIL;
                            lr_next    = NIL;
                            count_next = '0;
                            st_next    = S_DONE;
                        end
                        MODE_FIND:   st_next = S_F_HEAD;
                        MODE_INSERT: st_next = S_I_CHK;
                        default:     st_next = S_DONE;
                    endcase
                end
            end
            S_F_HEAD: st_next = S_F_HD2;
            S_F_HD2:
            begin
                cur_next = head_cur;
                st_next  = head_cur[8] ? S_DONE : S_F_RD;
            end
            S_F_RD: st_next = S_F_CMP;
            S_F_CMP:
            begin
                if (!evict_en_reg)
                begin
                    // direct mapped: no key check
                    status_next = ST_HIT;
                    hdl_next    = cur_reg[7:0];
                    skey_next   = mk_rd;
                    st_next     = S_DONE;
                end
                else if (mk_rd == key_reg)
                begin
                    status_next = ST_HIT;
                    hdl_next    = cur_reg[7:0];
                    skey_next   = key_reg;
                    s_next      = cur_reg;
                    ul_ret_next = 1'b0;
                    st_next     = (mr_reg == cur_reg) ? S_DONE : S_UL_RD;
                end
                else
                begin
                    cur_next = mc_rd;
                    st_next  = mc_rd[8] ? S_DONE : S_F_RD;
                end
            end
            S_UL_RD: st_next = S_UL_WR;
            S_UL_WR:
            begin
                // take s_reg out of the recency list
                if (mr_reg == s_reg)
                begin
                    mr_next = mn_rd;
                end
                else if (!mp_rd[8])
                begin
                    mn_we = 1'b1; mn_wa = mp_rd[7:0]; mn_wd = mn_rd;
                end
                if (lr_reg == s_reg)
                begin
                    lr_next = mp_rd;
                end
                else if (!mn_rd[8])
                begin
                    mp_we = 1'b1; mp_wa = mn_rd[7:0]; mp_wd = mp_rd;
                end
                st_next = ul_ret_reg ? S_EV_FIN : S_FR1;
            end
            S_FR1:
            begin
                // s_reg to the front
                mp_we = 1'b1; mp_wa = s_reg[7:0]; mp_wd = NIL;
                mn_we = 1'b1; mn_wa = s_reg[7:0]; mn_wd = mr_reg;
                st_next = S_FR2;
            end
            S_FR2:
            begin
                if (!mr_reg[8])
                begin
                    mp_we = 1'b1; mp_wa = mr_reg[7:0]; mp_wd = s_reg;
                end
                mr_next = s_reg;
                if (lr_reg[8])
                begin
                    lr_next = s_reg;
                end
                st_next = S_DONE;
            end
            S_EV0:
            begin
                if (lr_reg[8])
                begin
                    st_next = ev_ret_reg ? S_FS1 : S_I_HEAD;
                end
                else
                begin
                    s_next  = lr_reg;
                    st_next = S_EV_RD;
                end
            end
            S_EV_RD: st_next = S_EV_HD;
            S_EV_HD:
            begin
                evk_next = mk_rd;
                cn_next  = mc_rd;
                eb_next  = mk_rd[9:2];
                st_next  = S_EV_HD2;
            end
            S_EV_HD2:
            begin
                ul_ret_next = 1'b1;
                if (head_ev == s_reg)
                begin
                    mh_we = 1'b1; mh_wa = eb_reg; mh_wd = cn_reg;
                    st_next = S_UL_RD;
                end
                else if (head_ev[8])
                begin
                    st_next = S_UL_RD;
                end
                else
                begin
                    cur_next = head_ev;
                    st_next  = S_EV_WK;
                end
            end
            S_EV_WK: st_next = S_EV_WK2;
            S_EV_WK2:
            begin
                if (mc_rd == s_reg)
                begin
                    mc_we = 1'b1; mc_wa = cur_reg[7:0]; mc_wd = cn_reg;
                    st_next = S_UL_RD;
                end
                else if (mc_rd[8])
                begin
                    st_next = S_UL_RD;
                end
                else
                begin
                    cur_next = mc_rd;
                    st_next  = S_EV_WK;
                end
            end
            S_EV_FIN:
            begin
                valid_next[s_reg[7:0]] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                ev_next  = 1'b1;
                evh_next = s_reg[7:0];
                st_next  = ev_ret_reg ? S_FS1 : S_I_HEAD;
            end
            S_I_CHK:
            begin
                ev_ret_next = 1'b0;
                if (evict_en_reg && (count_reg > {1'b0, max_reg}))
                begin
                    st_next = S_EV0;
                end
                else
                begin
                    st_next = S_I_HEAD;
                end
            end
            S_I_HEAD: st_next = S_I_HD2;
            S_I_HD2:
            begin
                if (!evict_en_reg && !head_cur[8])
                begin
                    // overwrite the bucket's slot
                    mk_we = 1'b1; mk_wa = head_cur[7:0]; mk_wd = key_reg;
                    s_next      = head_cur;
                    status_next = ST_OVER;
                    hdl_next    = head_cur[7:0];
                    skey_next   = key_reg;
                    ul_ret_next = 1'b0;
                    st_next     = (mr_reg == head_cur) ? S_DONE : S_UL_RD;
                end
                else
                begin
                    st_next = S_FS1;
                end
            end
            S_FS1:
            begin
                grp_next    = grp_idx;
                grp_ok_next = grp_found;
                st_next     = S_FS2;
            end
            S_FS2:
            begin
                if (grp_ok_reg)
                begin
                    s_next  = {1'b0, grp_reg, bit_idx};
                    st_next = S_I_ALOC;
                end
                else if (!ev_reg && !tried_reg)
                begin
                    // table full: make room once
                    tried_next  = 1'b1;
                    ev_ret_next = 1'b1;
                    st_next     = S_EV0;
                end
                else
                begin
                    st_next = S_DONE;
                end
            end
            S_I_ALOC:
            begin
                valid_next[s_reg[7:0]] = 1'b1;
                mk_we = 1'b1; mk_wa = s_reg[7:0]; mk_wd = key_reg;
                mc_we = 1'b1; mc_wa = s_reg[7:0]; mc_wd = NIL;
                count_next  = count_reg + 1'b1;
                status_next = ST_NEW;
                hdl_next    = s_reg[7:0];
                skey_next   = key_reg;
                st_next     = S_I_H3;
            end
            S_I_H3:
            begin
                if (head_cur[8])
                begin
                    mh_we = 1'b1; mh_wa = bkt; mh_wd = s_reg;
                    bv_next[bkt] = 1'b1;
                    st_next = S_FR1;
                end
                else
                begin
                    cur_next = head_cur;
                    st_next  = S_I_WK;
                end
            end
            S_I_WK: st_next = S_I_WK2;
            S_I_WK2:
            begin
                if (mc_rd[8])
                begin
                    mc_we = 1'b1; mc_wa = cur_reg[7:0]; mc_wd = s_reg;
                    st_next = S_FR1;
                end
                else
                begin
                    cur_next = mc_rd;
                    st_next  = S_I_WK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_hdl_next     = hdl_reg;
                    o_skey_next    = skey_reg;
                    o_ev_next      = ev_reg;
                    o_evh_next     = evh_reg;
                    o_evk_next     = evk_reg;
                    o_cnt_next     = count_reg;
                    st_next        = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            valid_reg     <= '0;
            bv_reg        <= '0;
            count_reg     <= '0;
            mr_reg        <= NIL;
            lr_reg        <= NIL;
            evict_en_reg  <= 1'b1;
            max_reg       <= 8'd254;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            valid_reg     <= valid_next;
            bv_reg        <= bv_next;
            count_reg     <= count_next;
            mr_reg        <= mr_next;
            lr_reg        <= lr_next;
            evict_en_reg  <= evict_en_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        s_reg        <= s_next;
        cn_reg       <= cn_next;
        eb_reg       <= eb_next;
        grp_reg      <= grp_next;
        grp_ok_reg   <= grp_ok_next;
        ev_ret_reg   <= ev_ret_next;
        ul_ret_reg   <= ul_ret_next;
        tried_reg    <= tried_next;
        status_reg   <= status_next;
        hdl_reg      <= hdl_next;
        skey_reg     <= skey_next;
        ev_reg       <= ev_next;
        evh_reg      <= evh_next;
        evk_reg      <= evk_next;
        o_status_reg <= o_status_next;
        o_hdl_reg    <= o_hdl_next;
        o_skey_reg   <= o_skey_next;
        o_ev_reg     <= o_ev_next;
        o_evh_reg    <= o_evh_next;
        o_evk_reg    <= o_evk_next;
        o_cnt_reg    <= o_cnt_next;
    end

    assign in_ready       = (st_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign handle         = o_hdl_reg;
    assign stored_key     = o_skey_reg;
    assign evicted        = o_ev_reg;
    assign evicted_handle = o_evh_reg;
    assign evicted_key    = o_evk_reg;
    assign entry_count    = o_cnt_reg;

endmodule

/* design/atlru_chk.sv */
// Port-level checker for the address table, bound to the top level.
// Depends on atlru_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "address_table_with_lru_eviction_assert.svh"

module atlru_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [1:0]                     status,
    input logic [atlru_pkg::SLOT_W-1:0]   handle,
    input logic [atlru_pkg::KEY_W-1:0]    stored_key,
    input logic                           evicted,
    input logic [atlru_pkg::SLOT_W-1:0]   evicted_handle,
    input logic [atlru_pkg::KEY_W-1:0]    evicted_key,
    input logic [atlru_pkg::PTR_W-1:0]    entry_count
);

    import atlru_pkg::*;

    // a miss carries no slot
    `ATLRU_CHECK_NOW(a_miss_zero, out_valid && status == ST_MISS, handle == '0 && stored_key == '0, "miss with slot data")
    // no eviction, no victim data
    `ATLRU_CHECK_NOW(a_noev_zero, out_valid && !evicted, evicted_handle == '0 && evicted_key == '0, "victim data without eviction")
    // only an insert into a fresh slot, or a failed one, can evict
    `ATLRU_CHECK_NOW(a_ev_status, out_valid && evicted, status == ST_NEW || status == ST_MISS, "eviction on wrong status")
    // never more entries than slots
    `ATLRU_CHECK_NOW(a_count_max, out_valid, entry_count <= 9'd256, "entry count beyond capacity")
    // a stalled result holds
    `ATLRU_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(handle) && $stable(entry_count), "stalled result changed")

endmodule

bind address_table_with_lru_eviction atlru_chk u_atlru_chk (.*);

/* bench/address_table_with_lru_eviction_checker.sv */
// Checker for the address table: follows APB writes and both item channels,
// predicts each result and compares it. Depends on atlru_pkg.
`timescale 1ns / 1ps

module address_table_with_lru_eviction_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [31:0]                  key,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   status,
    input  logic [7:0]                   handle,
    input  logic [31:0]                  stored_key,
    input  logic                         evicted,
    input  logic [7:0]                   evicted_handle,
    input  logic [31:0]                  evicted_key,
    input  logic [8:0]                   entry_count,
    output int                           errors,
    output int                           awaiting,
    output int                           hits,
    output int                           evictions
);
    import atlru_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  handle;
        logic [31:0] stored_key;
        logic        evicted;
        logic [7:0]  evicted_handle;
        logic [31:0] evicted_key;
        logic [8:0]  entry_count;
    } lookup_result_t;

    // shadow of the table
    logic             chain_mode;
    logic [7:0]       evict_limit;
    logic             live [NSLOT];
    logic [31:0]      slot_addr [NSLOT];
    logic [PTR_W-1:0] head_of [NBKT];
    logic [PTR_W-1:0] next_in_chain [NSLOT];
    logic [PTR_W-1:0] older [NSLOT];
    logic [PTR_W-1:0] newer_link [NSLOT];
    logic [PTR_W-1:0] newest, oldest;
    logic [8:0]       held;

    lookup_result_t results_due [$];

    function automatic logic [7:0] bucket_of(logic [31:0] a);
        return a[9:2];
    endfunction

    // recency list: older[] points towards the newest end, newer_link[] away from it
    function automatic void lru_unlink(logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] p, n;
        p = older[s];
        n = newer_link[s];
        if (newest == s) newest = n;
        else if (p < NIL) newer_link[p] = n;
        if (oldest == s) oldest = p;
        else if (n < NIL) older[n] = p;
    endfunction

    function automatic void lru_front(logic [PTR_W-1:0] s);
        older[s] = NIL;
        newer_link[s] = newest;
        if (newest < NIL) older[newest] = s;
        newest = s;
        if (oldest >= NIL) oldest = s;
    endfunction

    function automatic void lru_touch(logic [PTR_W-1:0] s);
        if (newest == s) return;
        lru_unlink(s);
        lru_front(s);
    endfunction

    function automatic logic [PTR_W-1:0] drop_oldest();
        logic [PTR_W-1:0] s, cur;
        logic [7:0] b;
        s = oldest;
        if (s >= NIL) return NIL;
        b = bucket_of(slot_addr[s]);
        cur = head_of[b];
        if (cur == s) head_of[b] = next_in_chain[s];
        else
        begin
            for (int i = 0; i < NSLOT && cur < NIL; i++)
            begin
                if (next_in_chain[cur] == s)
                begin
                    next_in_chain[cur] = next_in_chain[s];
                    break;
                end
                cur = next_in_chain[cur];
            end
        end
        lru_unlink(s);
        live[s] = 1'b0;
        if (held > 0) held--;
        return s;
    endfunction

    function automatic logic [PTR_W-1:0] lowest_free();
        for (int i = 0; i < NSLOT; i++)
            if (!live[i]) return PTR_W'(i);
        return NIL;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < NSLOT; i++) live[i] = 1'b0;
        for (int i = 0; i < NBKT; i++) head_of[i] = NIL;
        newest = NIL;
        oldest = NIL;
        held = '0;
    endfunction

    function automatic lookup_result_t table_step(logic [1:0] m, logic [31:0] k);
        lookup_result_t r;
        logic [7:0] b;
        logic [PTR_W-1:0] s, cur, hd;
        int i;
        r = '0;
        b = bucket_of(k);
        if (m == MODE_CLEAR) wipe_table();
        else if (m == MODE_FIND)
        begin
            cur = head_of[b];
            if (!chain_mode)
            begin
                if (cur < NIL)
                begin
                    r.status = ST_HIT; r.handle = cur[7:0]; r.stored_key = slot_addr[cur];
                end
            end
            else
            begin
                for (i = 0; i < NSLOT && cur < NIL; i++)
                begin
                    if (slot_addr[cur] == k) break;
                    cur = next_in_chain[cur];
                end
                if (cur < NIL && i < NSLOT)
                begin
                    lru_touch(cur);
                    r.status = ST_HIT; r.handle = cur[7:0]; r.stored_key = k;
                end
            end
        end
        else if (m == MODE_INSERT)
        begin
            if (chain_mode && held > evict_limit)
            begin
                s = drop_oldest();
                if (s < NIL)
                begin
                    r.evicted = 1'b1; r.evicted_handle = s[7:0]; r.evicted_key = slot_addr[s];
                end
            end
            hd = head_of[b];
            if (!chain_mode && hd < NIL)
            begin
                slot_addr[hd] = k;
                lru_touch(hd);
                r.status = ST_OVER; r.handle = hd[7:0]; r.stored_key = k;
            end
            else
            begin
                s = lowest_free();
                if (s >= NIL && !r.evicted)
                begin
                    s = drop_oldest();
                    if (s < NIL)
                    begin
                        r.evicted = 1'b1; r.evicted_handle = s[7:0];
                        r.evicted_key = slot_addr[s];
                    end
                    s = lowest_free();
                end
                if (s < NIL)
                begin
                    live[s] = 1'b1;
                    slot_addr[s] = k;
                    next_in_chain[s] = NIL;
                    hd = head_of[b];
                    if (hd >= NIL) head_of[b] = s;
                    else
                    begin
                        cur = hd;
                        for (i = 0; i < NSLOT && next_in_chain[cur] < NIL; i++)
                            cur = next_in_chain[cur];
                        next_in_chain[cur] = s;
                    end
                    lru_front(s);
                    held++;
                    r.status = ST_NEW; r.handle = s[7:0]; r.stored_key = k;
                end
            end
        end
        r.entry_count = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t got, want;
        if (!rst_n)
        begin
            chain_mode = 1'b1;
            evict_limit = 8'd254;
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_addr[i] = '0; next_in_chain[i] = '0; older[i] = '0; newer_link[i] = '0;
            end
            wipe_table();
            results_due.delete();
            errors <= 0; awaiting <= 0; hits <= 0; evictions <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX) evict_limit = pwdata[7:0];
                else chain_mode = pwdata[0];
            end
            if (in_valid && in_ready)
                results_due.push_back(table_step(mode, key));
            if (out_valid && out_ready)
            begin
                got = '{status, handle, stored_key, evicted, evicted_handle,
                        evicted_key, entry_count};
                if (results_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result item %h", $realtime, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got != want)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch exp st=%0d h=%0d k=%h ev=%0d eh=%0d ek=%h n=%0d / got st=%0d h=%0d k=%h ev=%0d eh=%0d ek=%h n=%0d",
                                $realtime, want.status, want.handle, want.stored_key,
                                want.evicted, want.evicted_handle, want.evicted_key,
                                want.entry_count, got.status, got.handle, got.stored_key,
                                got.evicted, got.evicted_handle, got.evicted_key,
                                got.entry_count);
                        errors <= errors + 1;
                    end
                    if (want.status == ST_HIT) hits <= hits + 1;
                    if (want.evicted) evictions <= evictions + 1;
                end
            end
            awaiting <= results_due.size();
        end
    end

endmodule

/* bench/tb_address_table_with_lru_eviction.sv */
// Top of the address table bench: clock, reset, APB writes, item stimulus
// and verdict. Depends on atlru_pkg, the block and its checker.
`timescale 1ns / 1ps

module tb_address_table_with_lru_eviction;
    import atlru_pkg::*;

    localparam logic [1:0] MODE_NOP       = 2'd3;
    localparam logic [2:0] ADDR_EVICT_EN  = {REG_EVICT_EN, 2'b00};
    localparam logic [2:0] ADDR_MAX       = {REG_MAX, 2'b00};

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [1:0]  mode;
    logic [31:0] key;
    logic        out_valid, out_ready;
    logic [1:0]  status;
    logic [7:0]  handle, evicted_handle;
    logic [31:0] stored_key, evicted_key;
    logic        evicted;
    logic [8:0]  entry_count;

    int errors, awaiting, hits, evictions;
    int items_sent;

    // sender burst shaping
    int burst_left;
    // receiver: long hold-off request and a stall pattern that changes now and then
    logic hold_req;
    logic hold_on;
    int   pattern_age, stall_pct;

    // key pool for the random phases: few buckets so chains get deep
    logic [31:0] key_pool [24];

    address_table_with_lru_eviction uut (.*);

    address_table_with_lru_eviction_checker check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // long hold-off, counted in cycles once requested
    initial
    begin
        hold_on = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
    end

    // the receiver never lowers and raises out_ready in the same step
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            pattern_age <= 0;
            stall_pct <= 0;
        end
        else if (hold_on)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                // no stall, light stalls, heavy stalls
                case ($urandom_range(0, 2))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    default: stall_pct <= 80;
                endcase
                pattern_age <= $urandom_range(20, 200);
            end
            else
                pattern_age <= pattern_age - 1;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // offer one item and wait for acceptance; gaps only at burst ends
    task automatic send_item(input logic [1:0] m, input logic [31:0] k);
        in_valid <= 1'b1;
        mode <= m;
        key <= k;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // stop offering, wait for every result plus the block's tail
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic refill_pool(input int nbkt, input int base);
        for (int i = 0; i < 24; i++)
            key_pool[i] = {22'($urandom() >> 10), 8'(base + $urandom_range(0, nbkt - 1)),
                           2'($urandom_range(0, 3))};
    endtask

    // mostly inserts and finds over the pool, some clears, no-ops and stray keys
    task automatic random_traffic(input int n, input int nbkt, input int clear_pct);
        int r;
        logic [31:0] k;
        refill_pool(nbkt, $urandom_range(0, 255));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
            if (r < clear_pct) send_item(MODE_CLEAR, $urandom());
            else if (r < 55) send_item(MODE_INSERT, k);
            else if (r < 94) send_item(MODE_FIND, k);
            else send_item(MODE_NOP, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; mode = MODE_NOP; key = '0;
        hold_req = 1'b0;
        burst_left = 5;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty find, key extremes, duplicates, no-op, clear
        send_item(MODE_FIND, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);      // duplicate, appended at tail
        send_item(MODE_INSERT, 32'h0000_0400);      // same bucket, other key
        send_item(MODE_FIND, 32'h0000_0000);        // earliest duplicate wins
        send_item(MODE_FIND, 32'hFFFF_FFFF);
        send_item(MODE_FIND, 32'h0000_0400);
        send_item(MODE_FIND, 32'h0000_0800);        // same bucket, absent
        send_item(MODE_NOP, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 32'h0);
        send_item(MODE_FIND, 32'hFFFF_FFFF);
        settle();

        // max_entries zero: every insert past the first evicts
        apb_write(ADDR_MAX, 32'd0);
        random_traffic(60, 2, 2);
        settle();

        apb_write(ADDR_MAX, 32'd3);
        random_traffic(60, 4, 3);
        settle();

        // upper extreme, with a long receiver hold-off mid-stream
        apb_write(ADDR_MAX, 32'd254);
        hold_req = 1'b1;
        random_traffic(120, 4, 2);
        settle();

        apb_write(ADDR_MAX, $urandom_range(1, 20));
        random_traffic(70, 3, 2);
        settle();

        // fill to 255 entries in the lower half of the buckets
        apb_write(ADDR_MAX, 32'd254);
        send_item(MODE_CLEAR, 32'h0);
        for (int i = 0; i < 255; i++)
            send_item(MODE_INSERT, {22'($urandom() >> 10), 8'(i % 128),
                                    2'($urandom_range(0, 3))});
        settle();

        // direct mapped on top of the full table: last free slot, then no free slot
        apb_write(ADDR_EVICT_EN, 32'd0);
        send_item(MODE_INSERT, {22'h3ABCD, 8'd200, 2'd1});
        send_item(MODE_INSERT, {22'h12345, 8'd201, 2'd2});
        send_item(MODE_FIND, {22'h0, 8'd200, 2'd0});
        random_traffic(40, 8, 0);
        settle();

        // back to chains without a clear: stale structures used as they stand
        apb_write(ADDR_EVICT_EN, 32'd1);
        random_traffic(40, 8, 0);
        settle();

        // clean direct-mapped phase
        apb_write(ADDR_EVICT_EN, 32'd0);
        send_item(MODE_CLEAR, 32'h0);
        random_traffic(80, 8, 3);
        settle();

        apb_write(ADDR_EVICT_EN, 32'd1);
        send_item(MODE_CLEAR, 32'h0);
        random_traffic(60, 6, 2);
        settle();

        $display("Ran %0d items over chained and direct-mapped tables, limits 0 to 254.",
                 items_sent);
        $display("Seen %0d hits and %0d evictions.", hits, evictions);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", awaiting);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/atlru_pkg.sv
design/atlru_ram.sv
design/address_table_with_lru_eviction.sv
design/atlru_chk.sv
bench/address_table_with_lru_eviction_checker.sv
bench/tb_address_table_with_lru_eviction.sv
